/* design/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labelled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

/* design/fbjd_pkg.sv */
// Package for the face box jitter and distance block: field widths, register
// indexes, payload structs and the status struct of the bit-serial units.
// No dependencies.
package fbjd_pkg;

    localparam int BOX_W          = 10;
    localparam int CENTER_W       = 11;
    localparam int DIST_W         = 20;
    localparam int STAB_W         = 15;
    localparam int NUM_W          = 16;
    localparam int MIN_W          = 3;
    localparam int FRAC_W         = 4;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int WINDOW_DEFAULT = 5;

    localparam logic [NUM_W-1:0] RESET_DIST_NUM    = 16'd4760;
    localparam logic [MIN_W-1:0] RESET_MIN_SAMPLES = 3'd3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DIST_NUM    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SAMPLES = 2'd1;

    typedef struct packed {
        logic             face_found;
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_width;
        logic [BOX_W-1:0] box_height;
    } fbjd_in_t;

    typedef struct packed {
        logic              detected;
        logic [DIST_W-1:0] distance_q4;
        logic [STAB_W-1:0] stability_q4;
    } fbjd_out_t;

    // Status of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } fbjd_unit_stat_t;

    function automatic int fbjd_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* design/face_box_jitter_and_distance_core.sv */
// Top level of the face box jitter and distance block: sequencer, centre
// accumulation and result register. Depends on fbjd_pkg, fbjd_ring, fbjd_div, fbjd_sqrt.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+-------------------------------
//  frame   | frame_valid, frame_ready, frame      | one detection box per transaction
//  result  | result_valid, result_ready, result   | one result per transaction
//  cfg     | cfg_wr_en, cfg_addr, cfg_wr_data     | register write, no handshake
//
// A frame without a face goes straight to the done state and from there to the
// output register. A face runs through the bit-serial divider for the distance,
// the ring reads, the bit-serial root and the divider again for the final divide by
// n; a zero box width skips the distance divide, too few samples skip the rest.
// Reset clears the sample count, the write slot and the control registers; the ring
// and the payload registers are not cleared. A new frame is taken once the sequencer
// is idle, even while the previous result still waits in the output register.
module face_box_jitter_and_distance_core #(
    parameter int WINDOW = fbjd_pkg::WINDOW_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fbjd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fbjd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            frame_valid,
    output logic                            frame_ready,
    input  fbjd_pkg::fbjd_in_t              frame,
    output logic                            result_valid,
    input  logic                            result_ready,
    output fbjd_pkg::fbjd_out_t             result
);
    import fbjd_pkg::*;

    localparam int AW      = $clog2(WINDOW);
    localparam int NW      = $clog2(WINDOW + 1);
    localparam int ENTRY_W = 2 * CENTER_W;
    localparam int SUM_W   = CENTER_W + NW;
    localparam int SQ_W    = 2 * CENTER_W + NW;
    localparam int S_W     = 2 * CENTER_W + 2 * NW + 1;
    localparam int RAD_W   = S_W + 2 * FRAC_W + (S_W % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DVD_W   = fbjd_max(DIST_W, ROOT_W);
    localparam int CMP_W   = 8;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIST = 8'b0000_0010,
        ST_READ = 8'b0000_0100,
        ST_PROD = 8'b0000_1000,
        ST_DIFF = 8'b0001_0000,
        ST_SQRT = 8'b0010_0000,
        ST_QUOT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [NUM_W-1:0]    dist_num_reg, dist_num_next;
    logic [MIN_W-1:0]    min_samples_reg, min_samples_next;
    logic [AW-1:0]       write_slot_reg, write_slot_next;
    logic [NW-1:0]       sample_count_reg, sample_count_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                stab_en_reg, stab_en_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                pend_reg, pend_next;
    logic                div_start_reg, div_start_next;
    logic                sqrt_start_reg, sqrt_start_next;
    logic                result_valid_reg, result_valid_next;

    fbjd_in_t            frame_reg, frame_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [STAB_W-1:0]   stab_reg, stab_next;
    logic [SUM_W-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic [SQ_W-1:0]     qx_reg, qx_next, qy_reg, qy_next;
    logic [S_W-1:0]      t_reg, t_next;
    logic [2*SUM_W-1:0]  sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [S_W-1:0]      s_reg, s_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    fbjd_out_t           result_reg, result_next;

    logic                accept;
    logic [CENTER_W-1:0] cx, cy;
    logic [NW-1:0]       count_inc;
    logic [CMP_W-1:0]    min_eff;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic [CENTER_W-1:0] rx, ry;
    logic [ENTRY_W-1:0]  rx_sq, ry_sq;
    logic [SQ_W:0]       q_sum;
    logic [S_W-1:0]      n_times_q;
    logic [2*SUM_W-1:0]  sx_sq, sy_sq;
    logic [DVD_W-1:0]    div_dividend;
    logic [BOX_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    quotient;
    logic [ROOT_W-1:0]   sqrt_root;
    fbjd_unit_stat_t     div_stat;
    fbjd_unit_stat_t     sqrt_stat;

    assign accept      = frame_valid && frame_ready;
    assign frame_ready = (state_reg == ST_IDLE);

    // Box centre, each half-size truncated.
    assign cx = {1'b0, frame.box_left} + {2'b00, frame.box_width[BOX_W-1:1]};
    assign cy = {1'b0, frame.box_top} + {2'b00, frame.box_height[BOX_W-1:1]};

    assign count_inc = (sample_count_reg == NW'(WINDOW)) ? sample_count_reg
                                                          : sample_count_reg + 1'b1;
    assign min_eff   = (min_samples_reg == '0) ? CMP_W'(1) : CMP_W'(min_samples_reg);

    // Ring read data split into the two axes and squared.
    assign rx    = rd_data[CENTER_W-1:0];
    assign ry    = rd_data[ENTRY_W-1:CENTER_W];
    assign rx_sq = rx * rx;
    assign ry_sq = ry * ry;

    // Products for S = n * (qx + qy) - sx^2 - sy^2.
    assign q_sum     = {1'b0, qx_reg} + {1'b0, qy_reg};
    assign n_times_q = S_W'(n_reg) * S_W'(q_sum);
    assign sx_sq     = sx_reg * sx_reg;
    assign sy_sq     = sy_reg * sy_reg;

    // The divider serves the distance first and the final divide by n later.
    assign div_dividend = (state_reg == ST_QUOT) ? DVD_W'(root_reg)
                                                 : DVD_W'({dist_num_reg, {FRAC_W{1'b0}}});
    assign div_divisor  = (state_reg == ST_QUOT) ? BOX_W'(n_reg) : frame_reg.box_width;

    fbjd_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (ENTRY_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept && frame.face_found),
        .wr_addr (write_slot_reg),
        .wr_data ({cy, cx}),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    fbjd_div #(
        .DVD_W (DVD_W),
        .DVS_W (BOX_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    fbjd_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (RAD_W'({s_reg, {(2 * FRAC_W){1'b0}}})),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    // Configuration writes; unknown indexes are ignored.
    always_comb
    begin
        dist_num_next    = dist_num_reg;
        min_samples_next = min_samples_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_DIST_NUM:    dist_num_next    = cfg_wr_data[NUM_W-1:0];
                REG_MIN_SAMPLES: min_samples_next = cfg_wr_data[MIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        sample_count_next = sample_count_reg;
        n_next            = n_reg;
        stab_en_next      = stab_en_reg;
        rd_ptr_next       = rd_ptr_reg;
        issue_cnt_next    = issue_cnt_reg;
        pend_next         = 1'b0;
        div_start_next    = 1'b0;
        sqrt_start_next   = 1'b0;
        result_valid_next = result_valid_reg;
        frame_next        = frame_reg;
        dist_next         = dist_reg;
        stab_next         = stab_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        t_next            = t_reg;
        sqx_next          = sqx_reg;
        sqy_next          = sqy_reg;
        s_next            = s_reg;
        root_next         = root_reg;
        result_next       = result_reg;
        rd_en             = 1'b0;

        // The consumer takes the waiting result.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    frame_next     = frame;
                    dist_next      = '0;
                    stab_next      = '0;
                    sx_next        = '0;
                    sy_next        = '0;
                    qx_next        = '0;
                    qy_next        = '0;
                    rd_ptr_next    = write_slot_reg;
                    issue_cnt_next = '0;
                    if (!frame.face_found)
                    begin
                        sample_count_next = '0;
                        stab_en_next      = 1'b0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        write_slot_next   = (write_slot_reg == AW'(WINDOW - 1)) ? '0
                                            : write_slot_reg + 1'b1;
                        sample_count_next = count_inc;
                        n_next            = count_inc;
                        stab_en_next      = (CMP_W'(count_inc) >= min_eff);
                        if (frame.box_width != '0)
                        begin
                            div_start_next = 1'b1;
                            state_next     = ST_DIST;
                        end
                        else if (CMP_W'(count_inc) >= min_eff)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_DIST:
            begin
                if (div_stat.done)
                begin
                    dist_next  = quotient[DIST_W-1:0];
                    state_next = stab_en_reg ? ST_READ : ST_DONE;
                end
            end

            // Walk back from the newest entry, one read a cycle.
            ST_READ:
            begin
                if (issue_cnt_reg != n_reg)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_ptr_next    = (rd_ptr_reg == '0) ? AW'(WINDOW - 1) : rd_ptr_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    sx_next = sx_reg + SUM_W'(rx);
                    sy_next = sy_reg + SUM_W'(ry);
                    qx_next = qx_reg + SQ_W'(rx_sq);
                    qy_next = qy_reg + SQ_W'(ry_sq);
                end
                else if (issue_cnt_reg == n_reg)
                begin
                    state_next = ST_PROD;
                end
            end

            ST_PROD:
            begin
                t_next     = n_times_q;
                sqx_next   = sx_sq;
                sqy_next   = sy_sq;
                state_next = ST_DIFF;
            end

            ST_DIFF:
            begin
                s_next          = t_reg - S_W'(sqx_reg) - S_W'(sqy_reg);
                sqrt_start_next = 1'b1;
                state_next      = ST_SQRT;
            end

            ST_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    root_next      = sqrt_root;
                    div_start_next = 1'b1;
                    state_next     = ST_QUOT;
                end
            end

            ST_QUOT:
            begin
                if (div_stat.done)
                begin
                    stab_next  = quotient[STAB_W-1:0];
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next        = 1'b1;
                    result_next.detected     = frame_reg.face_found;
                    result_next.distance_q4  = dist_reg;
                    result_next.stability_q4 = stab_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dist_num_reg     <= RESET_DIST_NUM;
            min_samples_reg  <= RESET_MIN_SAMPLES;
            write_slot_reg   <= '0;
            sample_count_reg <= '0;
            n_reg            <= '0;
            stab_en_reg      <= 1'b0;
            rd_ptr_reg       <= '0;
            issue_cnt_reg    <= '0;
            pend_reg         <= 1'b0;
            div_start_reg    <= 1'b0;
            sqrt_start_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dist_num_reg     <= dist_num_next;
            min_samples_reg  <= min_samples_next;
            write_slot_reg   <= write_slot_next;
            sample_count_reg <= sample_count_next;
            n_reg            <= n_next;
            stab_en_reg      <= stab_en_next;
            rd_ptr_reg       <= rd_ptr_next;
            issue_cnt_reg    <= issue_cnt_next;
            pend_reg         <= pend_next;
            div_start_reg    <= div_start_next;
            sqrt_start_reg   <= sqrt_start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        dist_reg   <= dist_next;
        stab_reg   <= stab_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        t_reg      <= t_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        s_reg      <= s_next;
        root_reg   <= root_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* design/fbjd_ring.sv */
// Ring store of box centres: one write port and one registered read port.
// Depends on nothing but its parameters.
module fbjd_ring #(
    parameter int DEPTH  = 5,
    parameter int DATA_W = 22
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/fbjd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, DVD_W quotient bits.
// Depends on fbjd_pkg for the unit status struct.
module fbjd_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [DVS_W-1:0]         divisor,
    output fbjd_pkg::fbjd_unit_stat_t stat,
    output logic [DVD_W-1:0]         quotient
);
    import fbjd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] d_reg, d_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One restoring step: bring in the next dividend bit and try the divisor.
    always_comb
    begin
        shifted = {rem_reg, q_reg[DVD_W-1]};
        fits    = (shifted >= {1'b0, d_reg});
        diff    = shifted - {1'b0, d_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

/* design/fbjd_sqrt.sv */
// Digit-serial integer square root: two radicand bits in, one root bit out
// per cycle, RAD_W/2 root bits. Depends on fbjd_pkg for the unit status struct.
module fbjd_sqrt #(
    parameter int RAD_W = 38
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [RAD_W-1:0]         radicand,
    output fbjd_pkg::fbjd_unit_stat_t stat,
    output logic [RAD_W/2-1:0]       root
);
    import fbjd_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              fits;

    // One digit step: remainder takes the next bit pair, trial is 4*root + 1.
    always_comb
    begin
        shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (shifted >= trial);
        diff    = shifted - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

/* design/fbjd_checker.sv */
// Port-level checker for the face box jitter and distance block, bound to
// the top level. Depends on fbjd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbjd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            frame_valid,
    input logic                            frame_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input fbjd_pkg::fbjd_out_t             result
);
    import fbjd_pkg::*;

    logic frame_taken;
    logic result_stalled;
    logic result_empty;

    assign frame_taken    = frame_valid && frame_ready;
    assign result_stalled = result_valid && !result_ready;
    assign result_empty   = (result.distance_q4 == '0) && (result.stability_q4 == '0);

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_result_held, clk, rst_n, result_stalled, result_valid)
    `ASSERT_NEXT(a_result_stable, clk, rst_n, result_stalled, $stable(result))

    // A frame with no face reports nothing beyond that.
    `ASSERT_IMPLY(a_no_face_zero, clk, rst_n, result_valid && !result.detected, result_empty)

    // The block works on one frame at a time.
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, frame_taken, !frame_ready)

    // A new result never appears in the cycle right after a frame was taken
    // or while the block was idle.
    `ASSERT_IMPLY(a_result_from_work, clk, rst_n, $rose(result_valid), !$past(frame_ready))

endmodule

bind face_box_jitter_and_distance_core fbjd_checker u_fbjd_checker (.*);

/* dv/face_box_jitter_and_distance_core_tb.sv */
// Self-checking testbench for face_box_jitter_and_distance_core: a queue-fed frame driver,
// a result monitor and a behavioural copy of the distance and centre-jitter arithmetic.
// Depends on fbjd_pkg and the core RTL only.
`timescale 1ns / 1ps

module face_box_jitter_and_distance_core_tb;
    import fbjd_pkg::*;

    localparam int WINDOW         = WINDOW_DEFAULT;
    localparam int SEGMENTS       = 8;
    localparam int RANDOM_PER_SEG = 212;
    localparam int CFG_SETTLE     = 150;
    localparam int TAIL_CYCLES    = 200;

    // Indexes that map to no register; writes there must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  frame_valid  = 1'b0;
    logic                  frame_ready;
    fbjd_in_t              frame        = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    fbjd_out_t             result;

    // Stimulus queue, expected results and handshake bookkeeping.
    fbjd_in_t  pending_frames[$];
    fbjd_out_t expected_results[$];
    fbjd_out_t oldest_result;
    int        frames_queued   = 0;
    int        frames_accepted = 0;
    int        fail_count      = 0;
    int        send_idle_pct   = 0;
    int        recv_idle_pct   = 0;

    // Mirror of the block's registers and centre history.
    logic [NUM_W-1:0]    mirror_dist_num    = RESET_DIST_NUM;
    logic [MIN_W-1:0]    mirror_min_samples = RESET_MIN_SAMPLES;
    logic [CENTER_W-1:0] centre_x[WINDOW];
    logic [CENTER_W-1:0] centre_y[WINDOW];
    int                  next_slot    = 0;
    int                  filled_count = 0;

    // Random walk state for the box generator.
    int base_left   = 500;
    int base_top    = 500;
    int base_width  = 200;
    int base_height = 200;
    int spread      = 3;

    face_box_jitter_and_distance_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always #6 clk = ~clk;

    // Largest r with r*r <= v, built one bit at a time from the top.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Work out the result of one accepted frame and queue it.
    function automatic void predict_result(input fbjd_in_t f);
        fbjd_out_t   want;
        logic [63:0] dist_val;
        logic [63:0] n;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] qx;
        logic [63:0] qy;
        logic [63:0] spread_sum;
        logic [63:0] stab;
        int          idx;
        want = '0;
        frames_accepted++;
        if (!f.face_found)
        begin
            filled_count = 0;
        end
        else
        begin
            dist_val = '0;
            if (f.box_width != 0)
                dist_val = (64'(mirror_dist_num) * 64'd16) / 64'(f.box_width);
            centre_x[next_slot] = CENTER_W'(f.box_left) + CENTER_W'(f.box_width >> 1);
            centre_y[next_slot] = CENTER_W'(f.box_top) + CENTER_W'(f.box_height >> 1);
            next_slot = (next_slot + 1) % WINDOW;
            if (filled_count < WINDOW)
                filled_count++;
            stab = '0;
            if (filled_count >= int'(mirror_min_samples))
            begin
                n  = 64'(filled_count);
                sx = '0;
                sy = '0;
                qx = '0;
                qy = '0;
                for (int k = 0; k < filled_count; k++)
                begin
                    idx = (next_slot + WINDOW - 1 - k) % WINDOW;
                    sx += 64'(centre_x[idx]);
                    sy += 64'(centre_y[idx]);
                    qx += 64'(centre_x[idx]) * 64'(centre_x[idx]);
                    qy += 64'(centre_y[idx]) * 64'(centre_y[idx]);
                end
                spread_sum = (n * qx - sx * sx) + (n * qy - sy * sy);
                stab = floor_root(spread_sum * 64'd256) / n;
            end
            want.detected     = 1'b1;
            want.distance_q4  = dist_val[DIST_W-1:0];
            want.stability_q4 = stab[STAB_W-1:0];
        end
        expected_results.push_back(want);
    endfunction

    function automatic void queue_frame(input fbjd_in_t f);
        pending_frames.push_back(f);
        frames_queued++;
    endfunction

    function automatic fbjd_in_t make_box(input logic found, input int l, input int t,
                                          input int w, input int h);
        fbjd_in_t f;
        f.face_found = found;
        f.box_left   = BOX_W'(l);
        f.box_top    = BOX_W'(t);
        f.box_width  = BOX_W'(w);
        f.box_height = BOX_W'(h);
        return f;
    endfunction

    // Mostly a random coordinate, sometimes one of the two ends of the range.
    function automatic int corner_or_any();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 1023;
        return $urandom_range(1023);
    endfunction

    function automatic logic [BOX_W-1:0] wobble(input int centre, input int amount);
        int v;
        v = centre + int'($urandom_range(2 * amount)) - amount;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return BOX_W'(v);
    endfunction

    // A face that jitters round a slowly moving box, with occasional lost faces
    // and jumps to a new box, so that runs fill and wrap the window.
    function automatic fbjd_in_t random_frame();
        fbjd_in_t f;
        int       roll;
        if ($urandom_range(99) < 10)
        begin
            base_left   = corner_or_any();
            base_top    = corner_or_any();
            base_width  = corner_or_any();
            base_height = corner_or_any();
            case ($urandom_range(4))
                0: spread = 0;
                1: spread = 1;
                2: spread = 3;
                3: spread = 20;
                default: spread = 300;
            endcase
        end
        f.face_found = ($urandom_range(99) >= 8);
        f.box_left   = wobble(base_left, spread);
        f.box_top    = wobble(base_top, spread);
        f.box_width  = wobble(base_width, spread);
        f.box_height = wobble(base_height, spread);
        roll = $urandom_range(99);
        if (roll < 3)
            f.box_width = '0;
        else if (roll < 6)
            f.box_width = BOX_W'(1);
        return f;
    endfunction

    // Register write at the next edge, then mirror it.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_DIST_NUM:    mirror_dist_num    = data[NUM_W-1:0];
            REG_MIN_SAMPLES: mirror_min_samples = data[MIN_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued frame is accepted and its result has arrived.
    task automatic wait_for_drain();
        while (frames_accepted != frames_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Frame driver: offers the next pending frame, holding it until accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
        end
        else
        begin
            if (frame_valid && frame_ready)
                predict_result(frame);
            if (!frame_valid || frame_ready)
            begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frame       <= pending_frames.pop_front();
                    frame_valid <= 1'b1;
                end
                else
                begin
                    frame_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no frame outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (result.detected !== oldest_result.detected)
                    begin
                        $error("detected: expected %0d, actual %0d",
                               oldest_result.detected, result.detected);
                        fail_count++;
                    end
                    if (result.distance_q4 !== oldest_result.distance_q4)
                    begin
                        $error("distance_q4: expected %0d, actual %0d",
                               oldest_result.distance_q4, result.distance_q4);
                        fail_count++;
                    end
                    if (result.stability_q4 !== oldest_result.stability_q4)
                    begin
                        $error("stability_q4: expected %0d, actual %0d",
                               oldest_result.stability_q4, result.stability_q4);
                        fail_count++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("face_box_jitter_and_distance_core regression: fail");
        $finish;
    end

    // Sequencing: reset, then segments with their own register settings and idling.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg > 0)
            begin
                wait_for_drain();
                repeat (CFG_SETTLE) @(posedge clk);
                case (seg)
                    1:
                    begin
                        cfg_write(REG_DIST_NUM, 16'hFFFF);
                        cfg_write(REG_MIN_SAMPLES, 16'd5);
                    end
                    2:
                    begin
                        cfg_write(REG_DIST_NUM, 16'd1);
                        cfg_write(REG_MIN_SAMPLES, 16'd1);
                        cfg_write(REG_SPARE_A, 16'($urandom));
                        cfg_write(REG_SPARE_B, 16'hFFFF);
                    end
                    3:
                    begin
                        // Zero numerator, and a minimum of zero with the upper bits set.
                        cfg_write(REG_DIST_NUM, 16'd0);
                        cfg_write(REG_MIN_SAMPLES, 16'hFFF8);
                    end
                    4:
                    begin
                        // A minimum above the window keeps stability at zero.
                        cfg_write(REG_DIST_NUM, 16'($urandom));
                        cfg_write(REG_MIN_SAMPLES, 16'd7);
                    end
                    5:
                    begin
                        cfg_write(REG_DIST_NUM, 16'($urandom));
                        cfg_write(REG_MIN_SAMPLES, 16'(($urandom_range(8191) << 3) | 6));
                    end
                    6:
                    begin
                        cfg_write(REG_DIST_NUM, 16'($urandom));
                        cfg_write(REG_MIN_SAMPLES, 16'd4);
                    end
                    default:
                    begin
                        cfg_write(REG_DIST_NUM, RESET_DIST_NUM);
                        cfg_write(REG_MIN_SAMPLES, 16'd2);
                    end
                endcase
            end

            if (seg < 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 50;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Directed frames under the reset settings.
            if (seg == 0)
            begin
                queue_frame(make_box(1'b0, 0, 0, 0, 0));
                queue_frame(make_box(1'b0, 1023, 1023, 1023, 1023));
                queue_frame(make_box(1'b1, 0, 0, 0, 0));
                queue_frame(make_box(1'b1, 1023, 1023, 1023, 1023));
                queue_frame(make_box(1'b1, 0, 0, 1, 0));
                queue_frame(make_box(1'b1, 1023, 0, 1023, 0));
                queue_frame(make_box(1'b1, 0, 1023, 0, 1023));
                // Window full, next two wrap the write slot.
                queue_frame(make_box(1'b1, 512, 256, 100, 80));
                queue_frame(make_box(1'b1, 341, 682, 682, 341));
                // A lost face clears the history.
                queue_frame(make_box(1'b0, 700, 300, 50, 60));
                queue_frame(make_box(1'b1, 100, 100, 50, 50));
                queue_frame(make_box(1'b1, 101, 99, 50, 50));
                queue_frame(make_box(1'b1, 102, 98, 52, 48));
                queue_frame(make_box(1'b0, 1023, 1023, 0, 0));
                // A perfectly still face gives zero jitter.
                for (int k = 0; k < 6; k++)
                    queue_frame(make_box(1'b1, 600, 400, 200, 200));
                queue_frame(make_box(1'b1, 0, 0, 1023, 1));
                queue_frame(make_box(1'b1, 1023, 1023, 2, 2));
            end

            for (int i = 0; i < RANDOM_PER_SEG; i++)
                queue_frame(random_frame());
        end

        // Let the last results out, then watch for strays.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("face_box_jitter_and_distance_core regression: pass");
        else
            $display("face_box_jitter_and_distance_core regression: fail");
        $finish;
    end

endmodule
